>>> rtl/ldse_pkg.sv
// ----------------------------------------------------------------------------
// ldse_pkg
// Shared types, constants and the log(1 + exp(-x)) correction table for the
// log-domain accumulator.
// ----------------------------------------------------------------------------
package ldse_pkg;

  // Word format: signed, FRAC_BITS fraction bits in a 24-bit word
  localparam int WORD_W             = 24;
  localparam int FRAC_BITS          = 16;
  localparam int CORR_TABLE_ENTRIES = 256;

  // Table spans |d| in [0, 16.0): index = floor(|d| * N / 2^(FRAC_BITS + 4))
  localparam int RANGE_LOG2 = 4;
  localparam int DIFF_W     = WORD_W + 1;
  localparam int IDX_W      = $clog2(CORR_TABLE_ENTRIES);
  localparam int CNT_W      = $clog2(CORR_TABLE_ENTRIES + 1);
  localparam int MUL_W      = DIFF_W + CNT_W;
  localparam int CORR_W     = FRAC_BITS;

  localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  // -16.0 at reset
  localparam logic signed [WORD_W-1:0] REL_THRESHOLD_RST =
    WORD_W'(-(longint'(16) <<< FRAC_BITS));

  localparam logic [63:0] ONE_Q31 = 64'd1 << 31;

  typedef logic [CORR_W-1:0] corr_tab_t [CORR_TABLE_ENTRIES];

  typedef struct packed {
    logic signed [WORD_W-1:0] term_log;
    logic                     first_of_sum;
    logic                     row_start;
    logic                     last_of_sum;
  } item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] running_total;
    logic                     term_added;
    logic                     skip_row;
    logic                     sum_done;
  } result_t;

  typedef struct packed {
    logic row_skipping;
    logic finished;
  } status_t;

  // exp(-f) in Q31, f in [0, 1] in Q31; elaboration only
  function automatic logic [63:0] exp_neg_q31(input logic [63:0] f);
    logic [63:0] acc;
    logic [63:0] trm;
    acc = ONE_Q31;
    trm = ONE_Q31;
    for (int k = 1; k <= 20; k++) begin
      trm = ((trm * f) >> 31) / 64'(k);
      if (k[0]) begin
        acc = (acc >= trm) ? acc - trm : 64'd0;
      end else begin
        acc = acc + trm;
      end
    end
    return acc;
  endfunction

  // Restoring long division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // log(1 + y) in Q31 via 2*atanh(y / (2 + y)); elaboration only
  function automatic logic [63:0] log1p_q31(input logic [63:0] y);
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] p;
    logic [63:0] acc;
    t   = udiv64(y << 31, (ONE_Q31 << 1) + y);
    t2  = (t * t) >> 31;
    p   = t;
    acc = '0;
    for (int k = 0; k < 20; k++) begin
      acc = acc + p / 64'(2 * k + 1);
      p   = (p * t2) >> 31;
    end
    return acc << 1;
  endfunction

  // Entry k: log(1 + exp(-x)) at x = (k + 0.5) * 16 / N, rounded
  function automatic corr_tab_t build_corr_tab();
    corr_tab_t   tab;
    logic [63:0] e1;
    logic [63:0] num;
    logic [63:0] whole;
    logic [63:0] rem;
    logic [63:0] e;
    logic [63:0] l;
    e1 = exp_neg_q31(ONE_Q31);
    for (int k = 0; k < CORR_TABLE_ENTRIES; k++) begin
      num   = 64'((2 * k + 1) * 8);
      whole = num / CORR_TABLE_ENTRIES;
      rem   = num % CORR_TABLE_ENTRIES;
      e     = exp_neg_q31((rem << 31) / CORR_TABLE_ENTRIES);
      for (longint i = 0; i < longint'(whole); i++) begin
        e = (e * e1) >> 31;
      end
      l      = log1p_q31(e);
      tab[k] = CORR_W'(((l << FRAC_BITS) + (64'd1 << 30)) >> 31);
    end
    return tab;
  endfunction

  localparam corr_tab_t CORR_TAB = build_corr_tab();

endpackage

>>> rtl/ldse_log_add.sv
// ----------------------------------------------------------------------------
// ldse_log_add
// log(exp(a) + exp(b)) as max plus table correction, saturated.
// ----------------------------------------------------------------------------
module ldse_log_add (
  input  logic signed [ldse_pkg::WORD_W-1:0] total,
  input  logic signed [ldse_pkg::WORD_W-1:0] term,
  output logic signed [ldse_pkg::WORD_W-1:0] sum
);

  logic signed [ldse_pkg::DIFF_W-1:0] diff;
  logic        [ldse_pkg::DIFF_W-1:0] mag;
  logic signed [ldse_pkg::WORD_W-1:0] hi;
  logic        [ldse_pkg::MUL_W-1:0]  prod;
  logic        [ldse_pkg::MUL_W-1:0]  idx_full;
  logic        [ldse_pkg::IDX_W-1:0]  idx;
  logic        [ldse_pkg::CORR_W-1:0] corr;
  logic signed [ldse_pkg::WORD_W+1:0] wide;

  always_comb begin
    diff = ldse_pkg::DIFF_W'(total) - ldse_pkg::DIFF_W'(term);
    hi   = (total > term) ? total : term;
    mag  = diff[ldse_pkg::DIFF_W-1] ? ldse_pkg::DIFF_W'(-diff) : ldse_pkg::DIFF_W'(diff);
    prod = ldse_pkg::MUL_W'(mag) * ldse_pkg::MUL_W'(ldse_pkg::CORR_TABLE_ENTRIES);
    idx_full = prod >> (ldse_pkg::FRAC_BITS + ldse_pkg::RANGE_LOG2);
    idx  = idx_full[ldse_pkg::IDX_W-1:0];
    // far apart: correction is zero
    corr = (idx_full < ldse_pkg::MUL_W'(ldse_pkg::CORR_TABLE_ENTRIES))
           ? ldse_pkg::CORR_TAB[idx] : '0;
    wide = (ldse_pkg::WORD_W+2)'(hi) + $signed({2'b00, ldse_pkg::WORD_W'(corr)});
    if (wide > (ldse_pkg::WORD_W+2)'(ldse_pkg::WORD_MAX)) begin
      sum = ldse_pkg::WORD_MAX;
    end else if (wide < (ldse_pkg::WORD_W+2)'(ldse_pkg::WORD_MIN)) begin
      sum = ldse_pkg::WORD_MIN;
    end else begin
      sum = wide[ldse_pkg::WORD_W-1:0];
    end
  end

endmodule

>>> rtl/ldse_accum.sv
// ----------------------------------------------------------------------------
// ldse_accum
// Total and row/sum flags; decides load, add, drop or stop per item.
// ----------------------------------------------------------------------------
module ldse_accum (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               step,
  input  ldse_pkg::item_t                    item,
  input  logic signed [ldse_pkg::WORD_W-1:0] rel_threshold,
  output ldse_pkg::result_t                  result,
  output ldse_pkg::status_t                  status
);

  logic signed [ldse_pkg::WORD_W-1:0] total;
  logic signed [ldse_pkg::WORD_W-1:0] total_next;
  logic                               row_skipping;
  logic                               row_skipping_next;
  logic                               finished;
  logic                               finished_next;
  logic signed [ldse_pkg::WORD_W-1:0] lse_sum;
  logic signed [ldse_pkg::DIFF_W-1:0] rel;
  logic                               negligible;
  logic                               skipping_eff;

  ldse_log_add u_log_add (
    .total (total),
    .term  (item.term_log),
    .sum   (lse_sum)
  );

  always_comb begin
    rel          = ldse_pkg::DIFF_W'(item.term_log) - ldse_pkg::DIFF_W'(total);
    negligible   = rel < ldse_pkg::DIFF_W'(rel_threshold);
    skipping_eff = row_skipping && !item.row_start;

    total_next        = total;
    row_skipping_next = row_skipping;
    finished_next     = finished;
    result.term_added = 1'b0;
    result.skip_row   = 1'b0;
    result.sum_done   = 1'b0;

    priority if (item.first_of_sum) begin
      total_next        = item.term_log;
      row_skipping_next = 1'b0;
      finished_next     = item.last_of_sum;
      result.term_added = 1'b1;
      result.sum_done   = item.last_of_sum;
    end else if (finished) begin
      result.sum_done = 1'b1;
    end else begin
      row_skipping_next = skipping_eff;
      priority if (skipping_eff) begin
        result.skip_row = 1'b1;
      end else if (negligible) begin
        if (item.row_start) begin
          finished_next = 1'b1;
        end else begin
          row_skipping_next = 1'b1;
          result.skip_row   = 1'b1;
        end
      end else begin
        total_next        = lse_sum;
        result.term_added = 1'b1;
      end
      if (item.last_of_sum) begin
        finished_next = 1'b1;
      end
      result.sum_done = finished_next;
    end
    result.running_total = total_next;

    status.row_skipping = row_skipping;
    status.finished     = finished;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total        <= '0;
      row_skipping <= 1'b0;
      finished     <= 1'b0;
    end else if (step) begin
      total        <= total_next;
      row_skipping <= row_skipping_next;
      finished     <= finished_next;
    end
  end

endmodule

>>> rtl/log_domain_sum_early_stop.sv
// ----------------------------------------------------------------------------
// log_domain_sum_early_stop
// Log-sum-exp accumulator over a row-major double sum, with row drop and
// early stop once terms fall below the total plus a threshold.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register, from input transaction to result.
// Throughput: 1 transaction per cycle while out_stall is low; the total is
//   updated by a subtract, constant multiply, table read and saturating add.
// Reset (rst, synchronous): pipeline empty, total 0, flags clear,
//   rel_threshold = -16.0.
// ----------------------------------------------------------------------------
module log_domain_sum_early_stop (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_wen,
  input  logic signed [ldse_pkg::WORD_W-1:0] cfg_wdata,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [ldse_pkg::WORD_W-1:0] term_log,
  input  logic                               first_of_sum,
  input  logic                               row_start,
  input  logic                               last_of_sum,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [ldse_pkg::WORD_W-1:0] running_total,
  output logic                               term_added,
  output logic                               skip_row,
  output logic                               sum_done
);

  logic signed [ldse_pkg::WORD_W-1:0] rel_threshold;

  // input register stage
  logic              s1_valid;
  logic              s1_valid_next;
  ldse_pkg::item_t   s1_item;

  // result register
  logic              out_valid_next;
  ldse_pkg::result_t res;
  ldse_pkg::result_t res_reg;
  ldse_pkg::status_t stat;

  logic in_take;
  logic adv;

  // Stage 1 moves on when the result register is empty or being emptied;
  // the accumulator state steps on the same edge.
  assign adv      = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_next = s1_valid;
    if (in_take) begin
      s1_valid_next = 1'b1;
    end else if (adv) begin
      s1_valid_next = 1'b0;
    end

    out_valid_next = out_valid;
    if (adv) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rel_threshold <= ldse_pkg::REL_THRESHOLD_RST;
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wen) begin
        rel_threshold <= cfg_wdata;
      end
      s1_valid  <= s1_valid_next;
      out_valid <= out_valid_next;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item.term_log     <= term_log;
      s1_item.first_of_sum <= first_of_sum;
      s1_item.row_start    <= row_start;
      s1_item.last_of_sum  <= last_of_sum;
    end
    if (adv) begin
      res_reg <= res;
    end
  end

  ldse_accum u_accum (
    .clk           (clk),
    .rst           (rst),
    .step          (adv),
    .item          (s1_item),
    .rel_threshold (rel_threshold),
    .result        (res),
    .status        (stat)
  );

  assign running_total = res_reg.running_total;
  assign term_added    = res_reg.term_added;
  assign skip_row      = res_reg.skip_row;
  assign sum_done      = res_reg.sum_done;

  // A term is never both added and the trigger of a row skip.
  a_add_xor_skip: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(term_added && skip_row))
    else $error("term_added and skip_row both set");

  // An empty input stage never stalls the source.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("input stalled with empty stage");

  // Once finished, a non-opening item reports done and adds nothing.
  a_finished_hold: assert property (@(posedge clk) disable iff (rst)
    (adv && stat.finished && !s1_item.first_of_sum)
      |=> (out_valid && sum_done && !term_added && !skip_row))
    else $error("finished sum not held");

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - log-domain sum accumulator with early stop
// Drives row-major sums through log_domain_sum_early_stop and checks every
// result transaction against a predictor that keeps its own total, row-drop
// and finished flags. A short directed table comes first, with the obvious
// results typed in. Randomised sums, broken sums and noise follow, under
// several thresholds and with bursty input and output traffic.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     HALF_PERIOD  = 10;
  localparam int     CYCLE_LIMIT  = 500000;
  localparam int     HOLD_CYCLES  = 300;     // long receiver hold-off
  localparam int     PHASE_ITEMS  = 325;     // six random phases, ~1950 terms
  localparam int     NUM_PHASES   = 6;
  localparam longint TOT_MAX      = 8388607;
  localparam longint TOT_MIN      = -8388608;
  localparam longint THR_AT_RESET = -1048576;              // -16.0 in Q8.16
  localparam longint unsigned Q31_ONE = 64'd1 << 31;

  typedef enum logic {ROW_TERM, ROW_CFG} row_kind_t;
  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;
  typedef enum {SHAPE_CLEAN, SHAPE_BROKEN, SHAPE_NOISE} sum_shape_t;

  // One line of the directed table: a term transaction or a threshold write
  typedef struct packed {
    row_kind_t                          kind;
    logic signed [ldse_pkg::WORD_W-1:0] value;     // term_log, or the new threshold
    logic                               is_first;
    logic                               opens_row;
    logic                               is_last;
    logic                               typed;     // want holds the expected result
    ldse_pkg::result_t                  want;
  } row_t;

  // --------------------------------------------------------------------------
  // Clock and DUT signals
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;

  logic                               cfg_wen;
  logic signed [ldse_pkg::WORD_W-1:0] cfg_wdata;
  logic                               in_valid;
  logic                               in_stall;
  logic signed [ldse_pkg::WORD_W-1:0] term_log;
  logic                               first_of_sum;
  logic                               row_start;
  logic                               last_of_sum;
  logic                               out_valid;
  logic                               out_stall;
  logic signed [ldse_pkg::WORD_W-1:0] running_total;
  logic                               term_added;
  logic                               skip_row;
  logic                               sum_done;

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  log_domain_sum_early_stop u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .term_log      (term_log),
    .first_of_sum  (first_of_sum),
    .row_start     (row_start),
    .last_of_sum   (last_of_sum),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .running_total (running_total),
    .term_added    (term_added),
    .skip_row      (skip_row),
    .sum_done      (sum_done)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  longint  corr_lut [ldse_pkg::CORR_TABLE_ENTRIES];  // log(1 + exp(-x)) in Q8.16
  longint  acc_total;                      // predictor's copy of the total
  bit      acc_skipping;                   // rest of current row dropped
  bit      acc_finished;                   // sum closed
  longint  acc_thr;                        // predictor's copy of rel_threshold

  ldse_pkg::result_t pending_totals [$];   // expected results, oldest first
  ldse_pkg::result_t head_exp;
  row_t    dir_rows [$];

  int      fail_count   = 0;
  int      cycle_count  = 0;
  int      items_sent   = 0;
  int      phase_sent   = 0;
  int      results_seen = 0;
  int      n_added      = 0;
  int      n_skips      = 0;
  int      n_done       = 0;
  int      n_in_stalls  = 0;
  int      n_thr_writes = 0;
  int      burst_left   = 1;
  bit      hold_req     = 1'b0;            // asks the receiver for a long hold

  // --------------------------------------------------------------------------
  // Correction table, built with the same integer series as the RTL table:
  // entry k is log(1 + exp(-x)) at the bin midpoint x = (k + 0.5) * 16 / N.
  // --------------------------------------------------------------------------
  function automatic longint unsigned decay_q31(input longint unsigned f);
    longint unsigned acc;
    longint unsigned trm;
    acc = Q31_ONE;
    trm = Q31_ONE;
    for (int k = 1; k <= 20; k++) begin
      trm = ((trm * f) >> 31) / longint'(k);
      if (k % 2 == 1) begin
        acc = (acc >= trm) ? acc - trm : 64'd0;
      end else begin
        acc = acc + trm;
      end
    end
    return acc;
  endfunction

  initial begin
    longint unsigned e1, num, whole, rem, e, t, t2, p, acc;
    e1 = decay_q31(Q31_ONE);
    for (int k = 0; k < ldse_pkg::CORR_TABLE_ENTRIES; k++) begin
      num   = longint'((2 * k + 1) * 8);
      whole = num / ldse_pkg::CORR_TABLE_ENTRIES;
      rem   = num % ldse_pkg::CORR_TABLE_ENTRIES;
      e     = decay_q31((rem << 31) / ldse_pkg::CORR_TABLE_ENTRIES);
      for (longint unsigned i = 0; i < whole; i++) begin
        e = (e * e1) >> 31;
      end
      // log(1 + e) = 2 * atanh(e / (2 + e))
      t   = (e << 31) / (2 * Q31_ONE + e);
      t2  = (t * t) >> 31;
      p   = t;
      acc = 0;
      for (int j = 0; j < 20; j++) begin
        acc = acc + p / longint'(2 * j + 1);
        p   = (p * t2) >> 31;
      end
      acc = 2 * acc;
      corr_lut[k] = longint'(((acc << ldse_pkg::FRAC_BITS) + (64'd1 << 30)) >> 31);
    end
  end

  // --------------------------------------------------------------------------
  // Predictor: one accepted term in, one expected result out
  // --------------------------------------------------------------------------
  function automatic ldse_pkg::result_t lse_accumulate(input ldse_pkg::item_t it);
    ldse_pkg::result_t r;
    longint  term_v;
    longint  hi;
    longint  diff;
    longint  idx;
    longint  nxt;
    term_v = longint'(it.term_log);
    r      = '0;
    if (it.first_of_sum) begin
      // a new sum loads the total outright
      acc_total    = term_v;
      acc_skipping = 1'b0;
      acc_finished = it.last_of_sum;
      r.term_added = 1'b1;
      r.sum_done   = it.last_of_sum;
    end else if (acc_finished) begin
      r.sum_done = 1'b1;
    end else begin
      if (it.row_start) begin
        acc_skipping = 1'b0;
      end
      if (acc_skipping) begin
        r.skip_row = 1'b1;
      end else if (term_v - acc_total < acc_thr) begin
        // negligible: a row opener ends the sum, otherwise drop the row
        if (it.row_start) begin
          acc_finished = 1'b1;
        end else begin
          acc_skipping = 1'b1;
          r.skip_row   = 1'b1;
        end
      end else begin
        hi   = (acc_total > term_v) ? acc_total : term_v;
        diff = (acc_total > term_v) ? acc_total - term_v : term_v - acc_total;
        idx  = (diff * ldse_pkg::CORR_TABLE_ENTRIES) >>> (ldse_pkg::FRAC_BITS + 4);
        nxt  = hi;
        if (idx < ldse_pkg::CORR_TABLE_ENTRIES) begin
          nxt = nxt + corr_lut[idx];
        end
        if (nxt > TOT_MAX) begin
          nxt = TOT_MAX;
        end
        if (nxt < TOT_MIN) begin
          nxt = TOT_MIN;
        end
        acc_total    = nxt;
        r.term_added = 1'b1;
      end
      if (it.last_of_sum) begin
        acc_finished = 1'b1;
      end
      r.sum_done = acc_finished;
    end
    r.running_total = acc_total[ldse_pkg::WORD_W-1:0];
    return r;
  endfunction

  function automatic logic signed [ldse_pkg::WORD_W-1:0] clamp_word(input longint v);
    if (v > TOT_MAX) begin
      return ldse_pkg::WORD_W'(TOT_MAX);
    end
    if (v < TOT_MIN) begin
      return ldse_pkg::WORD_W'(TOT_MIN);
    end
    return ldse_pkg::WORD_W'(v);
  endfunction

  // --------------------------------------------------------------------------
  // Input side: one transaction per call, bursts with random gaps between
  // --------------------------------------------------------------------------
  task automatic send_item(input ldse_pkg::item_t it, input bit typed,
                           input ldse_pkg::result_t want);
    ldse_pkg::result_t pred;
    @(negedge clk);
    term_log     <= it.term_log;
    first_of_sum <= it.first_of_sum;
    row_start    <= it.row_start;
    last_of_sum  <= it.last_of_sum;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    // accepted at this edge; predictor always runs to keep its state in step
    pred = lse_accumulate(it);
    pending_totals.push_back(typed ? want : pred);
    items_sent++;
    phase_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      // no gaps while the receiver is holding off: keep the input pressed
      if (!hold_req) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(0, 5)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 12);
    end
  endtask

  // Sender pause: drop valid and wait until every result is back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_totals.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Threshold writes only while idle: results drained, then a wait covers the pipeline
  task automatic write_threshold(input logic signed [ldse_pkg::WORD_W-1:0] v);
    drain_results();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    acc_thr = longint'(v);
    n_thr_writes++;
  endtask

  // --------------------------------------------------------------------------
  // Random stimulus
  // --------------------------------------------------------------------------
  // A whole double sum, row-major, with terms drifting down from a base so
  // that both additions and early stops happen. Broken sums lose their first
  // or last flag, or get row starts added or removed at random.
  task automatic send_sum(input bit broken);
    ldse_pkg::item_t   it;
    ldse_pkg::result_t none;
    int      n_rows, n_cols, cols, step, amp;
    longint  base;
    bit      drop_first, drop_last;
    logic [31:0] raw;
    none       = '0;
    n_rows     = $urandom_range(1, 5);
    n_cols     = $urandom_range(1, 6);
    step       = $urandom_range(0, 262144);        // up to 4.0 per index
    amp        = $urandom_range(0, 131072);        // jitter up to 2.0
    drop_first = broken && ($urandom_range(0, 1) == 0);
    drop_last  = broken && ($urandom_range(0, 1) == 0);
    if ($urandom_range(0, 3) == 0) begin
      raw  = $urandom();
      base = longint'($signed(raw[ldse_pkg::WORD_W-1:0]));
    end else begin
      base = longint'($urandom_range(0, 2621440)) - 1310720;
    end
    for (int r = 0; r < n_rows; r++) begin
      cols = n_cols;
      // source honouring a skip request sends a short row
      if (r > 0 && $urandom_range(0, 3) == 0) begin
        cols = $urandom_range(1, n_cols);
      end
      for (int c = 0; c < cols; c++) begin
        it.term_log     = clamp_word(base - longint'(r + c) * step
                                     + longint'($urandom_range(0, 2 * amp)) - amp);
        it.first_of_sum = (r == 0 && c == 0) && !drop_first;
        it.row_start    = (c == 0) ^ (broken && $urandom_range(0, 7) == 0);
        it.last_of_sum  = (r == n_rows - 1 && c == cols - 1) && !drop_last;
        send_item(it, 1'b0, none);
      end
    end
  endtask

  task automatic send_noise();
    ldse_pkg::item_t   it;
    ldse_pkg::result_t none;
    logic [31:0]       raw;
    none            = '0;
    raw             = $urandom();
    it.term_log     = raw[ldse_pkg::WORD_W-1:0];
    it.first_of_sum = raw[24];
    it.row_start    = raw[25];
    it.last_of_sum  = raw[26];
    send_item(it, 1'b0, none);
  endtask

  task automatic run_phase(input logic signed [ldse_pkg::WORD_W-1:0] thr,
                           input bit with_hold);
    int         pause_at;
    bit         paused;
    bit         held;
    sum_shape_t shape;
    write_threshold(thr);
    phase_sent = 0;
    pause_at   = $urandom_range(50, PHASE_ITEMS - 50);
    paused     = 1'b0;
    held       = 1'b0;
    while (phase_sent < PHASE_ITEMS) begin
      if (!paused && phase_sent >= pause_at) begin
        drain_results();
        paused = 1'b1;
      end
      if (with_hold && !held && phase_sent >= 60) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      case ($urandom_range(0, 9))
        0:       shape = SHAPE_NOISE;
        1:       shape = SHAPE_BROKEN;
        default: shape = SHAPE_CLEAN;
      endcase
      if (shape == SHAPE_NOISE) begin
        send_noise();
      end else begin
        send_sum(shape == SHAPE_BROKEN);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  task automatic add_row(input row_kind_t k, input longint v,
                         input bit f, input bit rs, input bit l, input bit typed,
                         input longint wt, input bit wa, input bit ws, input bit wd);
    row_t row;
    row.kind               = k;
    row.value              = ldse_pkg::WORD_W'(v);
    row.is_first           = f;
    row.opens_row          = rs;
    row.is_last            = l;
    row.typed              = typed;
    row.want.running_total = ldse_pkg::WORD_W'(wt);
    row.want.term_added    = wa;
    row.want.skip_row      = ws;
    row.want.sum_done      = wd;
    dir_rows.push_back(row);
  endtask

  task automatic fill_directed();
    //      kind      term     fst rs lst typ  total    add skp done
    // default threshold (-16.0)
    add_row(ROW_TERM, 0,        0, 1, 0, 0, 0,        0, 0, 0);  // before any sum
    add_row(ROW_TERM, TOT_MAX,  1, 1, 0, 1, TOT_MAX,  1, 0, 0);  // load max
    add_row(ROW_TERM, TOT_MAX,  0, 0, 0, 1, TOT_MAX,  1, 0, 0);  // saturates high
    add_row(ROW_TERM, TOT_MIN,  0, 0, 0, 1, TOT_MAX,  0, 1, 0);  // negligible mid-row
    add_row(ROW_TERM, 0,        0, 0, 0, 1, TOT_MAX,  0, 1, 0);  // dropped row
    add_row(ROW_TERM, TOT_MAX,  0, 1, 0, 1, TOT_MAX,  1, 0, 0);  // new row resumes
    add_row(ROW_TERM, TOT_MIN,  0, 1, 0, 1, TOT_MAX,  0, 0, 1);  // negligible opener
    add_row(ROW_TERM, 5,        0, 0, 0, 1, TOT_MAX,  0, 0, 1);  // sum finished
    add_row(ROW_TERM, TOT_MIN,  1, 1, 1, 1, TOT_MIN,  1, 0, 1);  // first and last
    add_row(ROW_TERM, TOT_MAX,  0, 1, 0, 1, TOT_MIN,  0, 0, 1);  // ignored
    add_row(ROW_TERM, 0,        1, 1, 0, 1, 0,        1, 0, 0);
    add_row(ROW_TERM, TOT_MIN,  0, 0, 1, 1, 0,        0, 1, 1);  // dropped on last
    add_row(ROW_TERM, 0,        1, 1, 0, 1, 0,        1, 0, 0);
    add_row(ROW_TERM, 65536,    0, 1, 0, 0, 0,        0, 0, 0);
    add_row(ROW_TERM, 65536,    0, 0, 1, 0, 0,        0, 0, 0);  // added on last
    add_row(ROW_TERM, TOT_MIN,  1, 1, 0, 1, TOT_MIN,  1, 0, 0);  // load min
    add_row(ROW_TERM, TOT_MIN,  0, 0, 0, 0, 0,        0, 0, 0);  // min plus correction
    // threshold at zero: equal terms still add
    add_row(ROW_CFG,  0,        0, 0, 0, 0, 0,        0, 0, 0);
    add_row(ROW_TERM, 100,      1, 1, 0, 1, 100,      1, 0, 0);
    add_row(ROW_TERM, 100,      0, 0, 0, 0, 0,        0, 0, 0);
    add_row(ROW_TERM, 99,       0, 1, 0, 0, 0,        0, 0, 0);
    // positive threshold: even an equal term is dropped
    add_row(ROW_CFG,  65536,    0, 0, 0, 0, 0,        0, 0, 0);
    add_row(ROW_TERM, 100,      1, 1, 0, 1, 100,      1, 0, 0);
    add_row(ROW_TERM, 100,      0, 0, 0, 1, 100,      0, 1, 0);
    // threshold at its bottom end
    add_row(ROW_CFG,  TOT_MIN,  0, 0, 0, 0, 0,        0, 0, 0);
    add_row(ROW_TERM, TOT_MAX,  1, 1, 0, 1, TOT_MAX,  1, 0, 0);
    add_row(ROW_TERM, TOT_MIN,  0, 0, 1, 1, TOT_MAX,  0, 1, 1);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall pattern in segments, plus one long hold on request.
  // The hold length is counted here, independent of the sender.
  // --------------------------------------------------------------------------
  initial begin
    stall_mode_t mode;
    int          seg_len;
    int          held_for;
    out_stall = 1'b0;
    forever begin
      mode    = stall_mode_t'($urandom_range(0, 2));
      seg_len = $urandom_range(5, 80);
      repeat (seg_len) begin
        @(negedge clk);
        if (hold_req) begin
          out_stall <= 1'b1;
          held_for   = 0;
          while (held_for < HOLD_CYCLES) begin
            @(negedge clk);
            held_for++;
          end
          hold_req = 1'b0;
        end else begin
          case (mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            default:     out_stall <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: compare each accepted result with the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && in_valid && in_stall) begin
      n_in_stalls++;
    end
    if (!rst && out_valid && !out_stall) begin
      if (pending_totals.size() == 0) begin
        fail_count++;
        $error("result transaction with nothing expected (running_total %0d)",
               running_total);
      end else begin
        head_exp = pending_totals.pop_front();
        results_seen++;
        if (running_total !== head_exp.running_total) begin
          fail_count++;
          $error("running_total: expected %0d, got %0d",
                 head_exp.running_total, running_total);
        end
        if (term_added !== head_exp.term_added) begin
          fail_count++;
          $error("term_added: expected %0b, got %0b", head_exp.term_added, term_added);
        end
        if (skip_row !== head_exp.skip_row) begin
          fail_count++;
          $error("skip_row: expected %0b, got %0b", head_exp.skip_row, skip_row);
        end
        if (sum_done !== head_exp.sum_done) begin
          fail_count++;
          $error("sum_done: expected %0b, got %0b", head_exp.sum_done, sum_done);
        end
        n_added += term_added;
        n_skips += skip_row;
        n_done  += sum_done;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results outstanding",
             cycle_count, pending_totals.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    ldse_pkg::item_t                    it;
    logic signed [ldse_pkg::WORD_W-1:0] phase_thr [NUM_PHASES];
    logic [31:0]                        raw;

    // every DUT input known from time zero
    rst          = 1'b1;
    cfg_wen      = 1'b0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    term_log     = '0;
    first_of_sum = 1'b0;
    row_start    = 1'b0;
    last_of_sum  = 1'b0;

    acc_total    = 0;
    acc_skipping = 1'b0;
    acc_finished = 1'b0;
    acc_thr      = THR_AT_RESET;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table first
    fill_directed();
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_threshold(dir_rows[i].value);
      end else begin
        it.term_log     = dir_rows[i].value;
        it.first_of_sum = dir_rows[i].is_first;
        it.row_start    = dir_rows[i].opens_row;
        it.last_of_sum  = dir_rows[i].is_last;
        send_item(it, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // random phases: default, zero, the minimum, random negative, small positive,
    // and an unrestricted word so every threshold bit toggles
    raw          = $urandom();
    phase_thr[0] = ldse_pkg::WORD_W'(THR_AT_RESET);
    phase_thr[1] = '0;
    phase_thr[2] = ldse_pkg::WORD_W'(TOT_MIN);
    phase_thr[3] = ldse_pkg::WORD_W'(-longint'($urandom_range(1, 8388608)));
    phase_thr[4] = ldse_pkg::WORD_W'($urandom_range(1, 131072));
    phase_thr[5] = raw[ldse_pkg::WORD_W-1:0];
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      run_phase(phase_thr[ph], ph == 3);
    end

    // wind down: everything back, then an idle wait for anything stray
    drain_results();
    repeat (10) @(posedge clk);

    $display("Run covered %0d term transactions under %0d threshold writes, %0d results checked",
             items_sent, n_thr_writes, results_seen);
    $display("Terms added %0d, row drops %0d, sums done %0d, input stall cycles %0d",
             n_added, n_skips, n_done, n_in_stalls);
    if (fail_count == 0 && pending_totals.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
